FILE: src/pva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pva_pkg
// Shared widths, action codes and scan interface types of the voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

    // widest index and count over the supported pool sizes (up to 64 voices)
    localparam int MAX_IDX_W = 6;
    localparam int MAX_CNT_W = 7;

    // field widths
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int STAMP_W   = 32;
    localparam int ACTION_W  = 3;
    localparam int OUT_IDX_W = 4;
    localparam int OUT_CNT_W = 5;
    localparam int CFG_W     = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // event kinds
    localparam logic MODE_ON  = 1'b0;
    localparam logic MODE_OFF = 1'b1;

    // result actions
    localparam logic [ACTION_W-1:0] ACT_RETRIG  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STEAL   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_NOMATCH = 3'd4;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic                 clear;
        logic                 sample_valid;
        logic                 sample_busy;
        logic [MAX_IDX_W-1:0] sample_idx;
    } pva_scan_ctl_t;

    // accumulated scan results
    typedef struct packed {
        logic                 match_found;
        logic [MAX_IDX_W-1:0] match_idx;
        logic                 free_found;
        logic [MAX_IDX_W-1:0] free_idx;
        logic [MAX_IDX_W-1:0] oldest_idx;
        logic [MAX_CNT_W-1:0] busy_cnt;
    } pva_scan_res_t;

endpackage
`default_nettype wire

FILE: src/pva_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pva_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                       wdata,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: src/pva_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pva_scan
// Shared scan unit: one voice per cycle, tracks first note match, first free
// voice, oldest busy voice and the busy count.
// ----------------------------------------------------------------------------
module pva_scan (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pva_pkg::pva_scan_ctl_t        ctl,
    input  wire logic [pva_pkg::NOTE_W-1:0]    note,
    input  wire logic [pva_pkg::NOTE_W-1:0]    sample_pitch,
    input  wire logic [pva_pkg::STAMP_W-1:0]   sample_stamp,
    output pva_pkg::pva_scan_res_t             res
);
    import pva_pkg::*;

    logic                 match_found_reg, match_found_next;
    logic [MAX_IDX_W-1:0] match_idx_reg, match_idx_next;
    logic                 free_found_reg, free_found_next;
    logic [MAX_IDX_W-1:0] free_idx_reg, free_idx_next;
    logic                 min_valid_reg, min_valid_next;
    logic [MAX_IDX_W-1:0] min_idx_reg, min_idx_next;
    logic [STAMP_W-1:0]   min_stamp_reg, min_stamp_next;
    logic [MAX_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 hit;
    logic                 older;

    // the shared compares
    assign hit   = ctl.sample_busy && (sample_pitch == note);
    assign older = !min_valid_reg || (sample_stamp < min_stamp_reg);

    // accumulate over the scanned voices
    always_comb
    begin
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        min_valid_next   = min_valid_reg;
        min_idx_next     = min_idx_reg;
        min_stamp_next   = min_stamp_reg;
        cnt_next         = cnt_reg;
        if (ctl.clear)
        begin
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
            min_valid_next   = 1'b0;
            cnt_next         = '0;
        end
        else if (ctl.sample_valid)
        begin
            if (ctl.sample_busy)
            begin
                cnt_next = cnt_reg + MAX_CNT_W'(1);
            end
            if (hit && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = ctl.sample_idx;
            end
            if (!ctl.sample_busy && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = ctl.sample_idx;
            end
            if (ctl.sample_busy && older)
            begin
                min_valid_next = 1'b1;
                min_idx_next   = ctl.sample_idx;
                min_stamp_next = sample_stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            min_valid_reg   <= 1'b0;
            min_idx_reg     <= '0;
            min_stamp_reg   <= '0;
            cnt_reg         <= '0;
        end
        else
        begin
            match_found_reg <= match_found_next;
            match_idx_reg   <= match_idx_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            min_valid_reg   <= min_valid_next;
            min_idx_reg     <= min_idx_next;
            min_stamp_reg   <= min_stamp_next;
            cnt_reg         <= cnt_next;
        end
    end

    // result bundle
    always_comb
    begin
        res.match_found = match_found_reg;
        res.match_idx   = match_idx_reg;
        res.free_found  = free_found_reg;
        res.free_idx    = free_idx_reg;
        res.oldest_idx  = min_idx_reg;
        res.busy_cnt    = cnt_reg;
    end

endmodule
`default_nettype wire

FILE: src/poly_voice_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// poly_voice_allocator_top
// Polyphonic voice allocator with retrigger, free-voice and oldest-voice
// stealing policy; note-off frees the first busy voice with that note.
//
//   channel  | dir | tdata (low bit up)                         | tuser
//   s_axis   | in  | note_number, strike_velocity               | mode
//   m_axis   | out | voice_index, voice_note, voice_velocity,    | action
//            |     | start_stamp, active_count                  |
//   cfg      | in  | cfg_wdata = voices_in_use                  | -
//
// After its transfer each event passes the scan state, one voice per cycle
// through the single scan unit and the voice memories, then a drain state
// for the registered read and a commit state, before ready returns.
// Reset clears the busy flags, the stamp counter and sets the pool to 16;
// note and stamp memories need no clearing.
// A stalled result sits in the output register; the commit waits for it.
// ----------------------------------------------------------------------------
module poly_voice_allocator_top #(
    parameter int VOICES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pva_pkg::CFG_W-1:0]     cfg_wdata,     // voices_in_use
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [15:0]                   s_axis_tdata,  // note_number, strike_velocity
    input  wire logic                          s_axis_tuser,  // mode
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [55:0]                        m_axis_tdata,  // voice_index, voice_note,
                                                              // voice_velocity, start_stamp,
                                                              // active_count
    output logic [pva_pkg::ACTION_W-1:0]       m_axis_tuser   // action
);
    import pva_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W = $clog2(VOICES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CFG_W-1:0]     cfg_reg;
    logic                 mode_reg;
    logic [NOTE_W-1:0]    note_reg;
    logic [VEL_W-1:0]     vel_reg;
    logic [STAMP_W-1:0]   stamp_reg;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 samp_valid_reg;
    logic                 samp_busy_reg;
    logic [IDX_W-1:0]     samp_idx_reg;
    logic [VOICES-1:0]    busy_reg;

    logic                 out_valid_reg;
    logic [ACTION_W-1:0]  out_action_reg;
    logic [OUT_IDX_W-1:0] out_idx_reg;
    logic [NOTE_W-1:0]    out_note_reg;
    logic [VEL_W-1:0]     out_vel_reg;
    logic [STAMP_W-1:0]   out_stamp_reg;
    logic [OUT_CNT_W-1:0] out_cnt_reg;

    logic                 in_fire;
    logic                 out_load;
    logic [7:0]           pool_wide;
    logic [CNT_W-1:0]     pool;
    logic [IDX_W-1:0]     scan_idx;
    logic [IDX_W-1:0]     ram_addr;
    logic                 ram_we;
    logic [NOTE_W-1:0]    rd_pitch;
    logic [STAMP_W-1:0]   rd_stamp;
    pva_scan_ctl_t        scan_ctl;
    pva_scan_res_t        scan_res;

    logic [ACTION_W-1:0]  commit_action;
    logic [IDX_W-1:0]     commit_idx;
    logic [CNT_W-1:0]     commit_cnt;
    logic [CNT_W-1:0]     cnt_base;
    logic [MAX_IDX_W-1:0] idx_wide;
    logic [MAX_CNT_W-1:0] cnt_wide;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_load      = (state_reg == ST_COMMIT) && (!out_valid_reg || m_axis_tready);
    assign scan_idx      = scan_cnt_reg[IDX_W-1:0];

    // pool size clamped to 1 .. VOICES
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            pool_wide = 8'd1;
        end
        else if ({3'b000, cfg_reg} > 8'(VOICES))
        begin
            pool_wide = 8'(VOICES);
        end
        else
        begin
            pool_wide = {3'b000, cfg_reg};
        end
    end
    assign pool = pool_wide[CNT_W-1:0];

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg == pool - CNT_W'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            samp_valid_reg <= 1'b0;
            samp_busy_reg  <= 1'b0;
            samp_idx_reg   <= '0;
            stamp_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            samp_valid_reg <= (state_reg == ST_SCAN);
            samp_busy_reg  <= busy_reg[scan_idx];
            samp_idx_reg   <= scan_idx;
            if (in_fire && (s_axis_tuser == MODE_ON))
            begin
                stamp_reg <= stamp_reg + STAMP_W'(1);
            end
        end
    end

    // event capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg <= s_axis_tuser;
            note_reg <= s_axis_tdata[NOTE_W-1:0];
            vel_reg  <= s_axis_tdata[NOTE_W+VEL_W-1:NOTE_W];
        end
    end

    // voice note and stamp memories
    assign ram_we   = (state_reg == ST_COMMIT) && (mode_reg == MODE_ON);
    assign ram_addr = (state_reg == ST_COMMIT) ? commit_idx : scan_idx;

    pva_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (VOICES)
    ) u_pitch_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (note_reg),
        .rdata (rd_pitch)
    );

    pva_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (VOICES)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (stamp_reg),
        .rdata (rd_stamp)
    );

    // scan unit
    always_comb
    begin
        scan_ctl.clear        = in_fire;
        scan_ctl.sample_valid = samp_valid_reg;
        scan_ctl.sample_busy  = samp_busy_reg;
        scan_ctl.sample_idx   = MAX_IDX_W'(samp_idx_reg);
    end

    pva_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (scan_ctl),
        .note         (note_reg),
        .sample_pitch (rd_pitch),
        .sample_stamp (rd_stamp),
        .res          (scan_res)
    );

    // allocation decision
    assign cnt_base = scan_res.busy_cnt[CNT_W-1:0];
    always_comb
    begin
        commit_action = ACT_NOMATCH;
        commit_idx    = '0;
        commit_cnt    = cnt_base;
        if (mode_reg == MODE_ON)
        begin
            if (scan_res.match_found)
            begin
                commit_action = ACT_RETRIG;
                commit_idx    = scan_res.match_idx[IDX_W-1:0];
            end
            else if (scan_res.free_found)
            begin
                commit_action = ACT_FREE;
                commit_idx    = scan_res.free_idx[IDX_W-1:0];
                commit_cnt    = cnt_base + CNT_W'(1);
            end
            else
            begin
                commit_action = ACT_STEAL;
                commit_idx    = scan_res.oldest_idx[IDX_W-1:0];
            end
        end
        else if (scan_res.match_found)
        begin
            commit_action = ACT_RELEASE;
            commit_idx    = scan_res.match_idx[IDX_W-1:0];
            commit_cnt    = cnt_base - CNT_W'(1);
        end
    end

    assign idx_wide = MAX_IDX_W'(commit_idx);
    assign cnt_wide = MAX_CNT_W'(commit_cnt);

    // busy flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if (out_load && (commit_action != ACT_NOMATCH))
        begin
            busy_reg[commit_idx] <= (mode_reg == MODE_ON);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_action_reg <= commit_action;
            out_idx_reg    <= idx_wide[OUT_IDX_W-1:0];
            out_note_reg   <= (commit_action == ACT_NOMATCH) ? '0 : note_reg;
            out_vel_reg    <= (mode_reg == MODE_ON) ? vel_reg : '0;
            out_stamp_reg  <= (mode_reg == MODE_ON) ? stamp_reg : '0;
            out_cnt_reg    <= cnt_wide[OUT_CNT_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_action_reg;
    assign m_axis_tdata  = {1'b0, out_cnt_reg, out_stamp_reg, out_vel_reg,
                            out_note_reg, out_idx_reg};

    // a steal happens only with every voice in the pool busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && mode_reg == MODE_ON && !scan_res.match_found
         && !scan_res.free_found) |-> (scan_res.busy_cnt == MAX_CNT_W'(pool)))
        else $error("steal with a free voice in the pool");

    // the active count never exceeds the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (cnt_wide <= MAX_CNT_W'(pool)))
        else $error("active count above pool size");

    // a note-on advances the stamp by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tuser == MODE_ON) |=> (stamp_reg == $past(stamp_reg) + STAMP_W'(1)))
        else $error("stamp did not advance on note-on");

    // a release leaves the voice free
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && commit_action == ACT_RELEASE) |=> !busy_reg[$past(commit_idx)])
        else $error("released voice still busy");

    // the scan ends before the result is committed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> !samp_valid_reg)
        else $error("scan sample pending at commit");

endmodule
`default_nettype wire

FILE: tb/sv/poly_voice_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_voice_allocator_top_tb
// Self-checking bench for the voice allocator. Note-on and note-off events
// are streamed in. A voice-pool model predicts the voice, action, stamp and
// active count of each event. The bench walks through several pool sizes,
// among them the out-of-range register values, and stalls both sides.
// ----------------------------------------------------------------------------
module poly_voice_allocator_top_tb;
    import pva_pkg::*;

    localparam int NUM_VOICES   = 16;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AT      = 700;
    localparam int PHASE_EVENTS = 195;

    // one allocation result, fields as they leave the block
    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [OUT_IDX_W-1:0] voice_index;
        logic [NOTE_W-1:0]    voice_note;
        logic [VEL_W-1:0]     voice_velocity;
        logic [STAMP_W-1:0]   start_stamp;
        logic [OUT_CNT_W-1:0] active_count;
    } alloc_result_t;

    // voice pool model and queue of expected allocations
    class voice_alloc_scoreboard;
        bit                 busy [NUM_VOICES];
        bit [NOTE_W-1:0]    pitch [NUM_VOICES];
        bit [STAMP_W-1:0]   age [NUM_VOICES];
        bit [STAMP_W-1:0]   stamp_ctr;
        bit [CFG_W-1:0]     pool_reg = CFG_RESET;
        alloc_result_t      pending_allocs [$];
        int                 errors;

        function void set_pool(logic [CFG_W-1:0] value);
            pool_reg = value;
        endfunction

        function int pending();
            return pending_allocs.size();
        endfunction

        // register value 0 acts as one voice, above the pool acts as all
        function int pool_voices();
            if (pool_reg == 0)
                return 1;
            if (pool_reg > NUM_VOICES)
                return NUM_VOICES;
            return int'(pool_reg);
        endfunction

        // predict the allocation caused by one accepted event
        function void note_event(logic mode, logic [NOTE_W-1:0] note, logic [VEL_W-1:0] vel);
            alloc_result_t r;
            int            n;
            int            hit;
            int            cnt;
            r   = '0;
            n   = pool_voices();
            hit = -1;
            cnt = 0;
            for (int v = 0; v < n; v++)
                if (hit < 0 && busy[v] && pitch[v] == note)
                    hit = v;
            if (mode == MODE_ON) begin
                stamp_ctr++;
                if (hit >= 0) begin
                    r.action = ACT_RETRIG;
                end
                else begin
                    for (int v = 0; v < n; v++)
                        if (hit < 0 && !busy[v])
                            hit = v;
                    if (hit >= 0) begin
                        r.action = ACT_FREE;
                    end
                    else begin
                        // steal the oldest voice, lowest index on ties
                        r.action = ACT_STEAL;
                        hit = 0;
                        for (int v = 1; v < n; v++)
                            if (age[v] < age[hit])
                                hit = v;
                    end
                end
                busy[hit]        = 1'b1;
                pitch[hit]       = note;
                age[hit]         = stamp_ctr;
                r.voice_index    = OUT_IDX_W'(hit);
                r.voice_note     = note;
                r.voice_velocity = vel;
                r.start_stamp    = stamp_ctr;
            end
            else if (hit >= 0) begin
                r.action      = ACT_RELEASE;
                busy[hit]     = 1'b0;
                r.voice_index = OUT_IDX_W'(hit);
                r.voice_note  = note;
            end
            else begin
                r.action = ACT_NOMATCH;
            end
            for (int v = 0; v < n; v++)
                if (busy[v])
                    cnt++;
            r.active_count = OUT_CNT_W'(cnt);
            pending_allocs.push_back(r);
        endfunction

        // compare one output transfer with the oldest expected allocation
        function void check_allocation(logic [55:0] data, logic [ACTION_W-1:0] act);
            alloc_result_t exp_r;
            alloc_result_t got;
            if (pending_allocs.size() == 0) begin
                $error("result transfer with no event outstanding: action %0d", act);
                errors++;
                return;
            end
            exp_r              = pending_allocs.pop_front();
            got.action         = act;
            got.voice_index    = data[3:0];
            got.voice_note     = data[10:4];
            got.voice_velocity = data[17:11];
            got.start_stamp    = data[49:18];
            got.active_count   = data[54:50];
            if (got.action !== exp_r.action) begin
                $error("action: expected %0d, actual %0d", exp_r.action, got.action);
                errors++;
            end
            if (got.voice_index !== exp_r.voice_index) begin
                $error("voice_index: expected %0d, actual %0d",
                       exp_r.voice_index, got.voice_index);
                errors++;
            end
            if (got.voice_note !== exp_r.voice_note) begin
                $error("voice_note: expected %0d, actual %0d",
                       exp_r.voice_note, got.voice_note);
                errors++;
            end
            if (got.voice_velocity !== exp_r.voice_velocity) begin
                $error("voice_velocity: expected %0d, actual %0d",
                       exp_r.voice_velocity, got.voice_velocity);
                errors++;
            end
            if (got.start_stamp !== exp_r.start_stamp) begin
                $error("start_stamp: expected %0d, actual %0d",
                       exp_r.start_stamp, got.start_stamp);
                errors++;
            end
            if (got.active_count !== exp_r.active_count) begin
                $error("active_count: expected %0d, actual %0d",
                       exp_r.active_count, got.active_count);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata = '0;   // note_number, strike_velocity
    logic                s_axis_tuser = 1'b0; // mode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [55:0]         m_axis_tdata;        // voice_index, voice_note, voice_velocity,
                                              // start_stamp, active_count
    logic [ACTION_W-1:0] m_axis_tuser;        // action

    voice_alloc_scoreboard sb = new;
    int                    results_seen = 0;

    poly_voice_allocator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        forever #4 clk = ~clk;
    end

    // run limit
    initial begin
        #12_000_000;
        $display("Mismatches found");
        $finish;
    end

    // idle length: mostly none or short, a few long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // offer one event and wait for its transfer
    task automatic send_event(input logic mode, input logic [NOTE_W-1:0] note,
                              input logic [VEL_W-1:0] vel);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, vel, note};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_event(mode, note, vel);
    endtask

    // stop offering, wait for all results and let the commit settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_pool(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_pool(value);
    endtask

    // random events over a narrow note window so retrigger, steal and release occur
    task automatic run_phase(input logic [CFG_W-1:0] pool_value, input int events);
        int                voices;
        int                width;
        int                base;
        logic              mode;
        logic [NOTE_W-1:0] note;
        write_pool(pool_value);
        voices = (pool_value == 0) ? 1 : ((pool_value > NUM_VOICES) ? NUM_VOICES : pool_value);
        width  = voices + 4;
        base   = $urandom_range(0, 128 - width);
        for (int i = 0; i < events; i++) begin
            if ($urandom_range(0, 4) == 0)
                note = NOTE_W'($urandom_range(0, 127));
            else
                note = NOTE_W'(base + $urandom_range(0, width - 1));
            mode = ($urandom_range(0, 99) < 40) ? MODE_OFF : MODE_ON;
            send_event(mode, note, VEL_W'($urandom_range(0, 127)));
        end
    endtask

    // result monitor
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_allocation(m_axis_tdata, m_axis_tuser);
            results_seen <= results_seen + 1;
        end
    end

    // receiver: random stalls plus one long hold-off to back up the input
    initial begin
        int  stall;
        bit  held;
        held = 1'b0;
        @(posedge clk);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (!held && results_seen >= HOLD_AT) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            else begin
                stall = idle_gap();
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // stimulus
    initial begin
        logic [CFG_W-1:0] pools [10];
        pools = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd2, 5'd8, 5'd17, 5'd12, 5'd0};
        pools[9] = CFG_W'($urandom_range(1, 31));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // three voices: free, retrigger, steal, release, no match
        write_pool(5'd3);
        send_event(MODE_ON,  7'd0,   7'd127);
        send_event(MODE_ON,  7'd127, 7'd0);
        send_event(MODE_ON,  7'd0,   7'd85);
        send_event(MODE_ON,  7'd42,  7'd42);
        send_event(MODE_ON,  7'd100, 7'd1);
        send_event(MODE_OFF, 7'd127, 7'd127);
        send_event(MODE_OFF, 7'd0,   7'd0);
        send_event(MODE_OFF, 7'd0,   7'd0);
        send_event(MODE_ON,  7'd7,   7'd99);

        // register zero acts as a single voice
        write_pool(5'd0);
        send_event(MODE_ON,  7'd10,  7'd64);
        send_event(MODE_ON,  7'd11,  7'd33);
        send_event(MODE_OFF, 7'd11,  7'd5);
        send_event(MODE_OFF, 7'd10,  7'd5);

        // register above the pool acts as all voices; parked voices come back
        write_pool(5'd31);
        send_event(MODE_ON,  7'd42,  7'd17);
        send_event(MODE_OFF, 7'd100, 7'd0);
        send_event(MODE_ON,  7'd127, 7'd127);
        send_event(MODE_OFF, 7'd7,   7'd0);

        // random phases over several pool sizes
        foreach (pools[p])
            run_phase(pools[p], PHASE_EVENTS);

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
src/pva_pkg.sv
src/pva_ram.sv
src/pva_scan.sv
src/poly_voice_allocator_top.sv
tb/sv/poly_voice_allocator_top_tb.sv
